FILE: rtl/core/sktab_pkg.sv
package sktab_pkg;

   localparam int CMD_W           = 2;
   localparam int KEY_W           = 32;
   localparam int STATUS_W        = 2;
   localparam int POS_W           = 6;
   localparam int TABLE_DEPTH_DEF = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_SEQ  = 2'd1,
      CMD_BIN  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_LOADED = 2'd0,
      RS_FOUND  = 2'd1,
      RS_MISS   = 2'd2,
      RS_FULL   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEQ_SCAN,
      ST_SORT_HOLD,
      ST_SORT_STEP,
      ST_SORT_END,
      ST_BS_ADDR,
      ST_BS_CMP,
      ST_RESPOND
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_SEQ_FIRST,
      OP_SEQ_SCAN,
      OP_SORT_INIT,
      OP_SORT_HOLD,
      OP_SORT_STEP,
      OP_SORT_END,
      OP_BS_ADDR,
      OP_BS_CMP,
      OP_POST
   } dp_op_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             count_zero;
      logic             count_lt2;
      logic             seq_hit;
      logic             seq_at_zero;
      logic             j_at_lim;
      logic             lim_at_one;
      logic             bs_empty;
      logic             bs_hit;
      logic             out_free;
   } dp_stat_type;

endpackage

FILE: rtl/core/sktab_if.sv
interface sktab_req_if;
   logic                                valid;
   logic                                ready;
   logic        [sktab_pkg::CMD_W-1:0]  cmd;
   logic signed [sktab_pkg::KEY_W-1:0]  key;
   logic                                restart;

   modport source (output valid, output cmd, output key, output restart, input ready);
   modport sink   (input valid, input cmd, input key, input restart, output ready);
endinterface

interface sktab_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sktab_pkg::STATUS_W-1:0]       status;
   logic [sktab_pkg::POS_W-1:0]          position;

   modport source (output valid, output status, output position, input ready);
   modport sink   (input valid, input status, input position, output ready);
endinterface

FILE: rtl/core/sktab_datapath.sv
module sktab_datapath #(
   parameter int TABLE_DEPTH = sktab_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sktab_pkg::dp_op_type                op,
   input  logic        [sktab_pkg::CMD_W-1:0]  req_cmd,
   input  logic signed [sktab_pkg::KEY_W-1:0]  req_key,
   input  logic                                req_restart,
   output sktab_pkg::dp_stat_type              stat,
   sktab_rsp_if.source                         rsp_if
);
   import sktab_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];

   logic signed [KEY_W-1:0] rd_data_ff;
   logic        [CMD_W-1:0] cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    restart_ff, restart_in;
   logic        [CW-1:0]    count_ff, count_in;
   logic        [IW-1:0]    p_ff, p_in;
   logic        [IW-1:0]    j_ff, j_in;
   logic        [IW-1:0]    lim_ff, lim_in;
   logic signed [KEY_W-1:0] hold_ff, hold_in;
   logic        [CW-1:0]    lo_ff, lo_in;
   logic        [CW-1:0]    end_ff, end_in;
   logic        [IW-1:0]    mid_ff, mid_in;
   status_type              res_status_ff, res_status_in;
   logic        [IW-1:0]    res_idx_ff, res_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]        rsp_pos_ff, rsp_pos_in;

   logic                    wr_en;
   logic        [IW-1:0]    wr_addr;
   logic signed [KEY_W-1:0] wr_data;
   logic        [IW-1:0]    rd_addr;
   logic        [CW-1:0]    eff_count;
   logic        [IW-1:0]    last_idx;
   logic        [CW:0]      mid_sum;
   logic        [IW-1:0]    mid_calc;
   logic                    key_hit;
   logic                    key_gt;
   logic                    swap;

   assign eff_count = restart_ff ? '0 : count_ff;
   assign last_idx  = IW'(count_ff - CW'(1));
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, end_ff} - (CW+1)'(1);
   assign mid_calc  = IW'(mid_sum >> 1);
   assign key_hit   = (rd_data_ff == key_ff);
   assign key_gt    = (rd_data_ff > key_ff);
   assign swap      = (hold_ff > rd_data_ff);

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      restart_in    = restart_ff;
      count_in      = count_ff;
      p_in          = p_ff;
      j_in          = j_ff;
      lim_in        = lim_ff;
      hold_in       = hold_ff;
      lo_in         = lo_ff;
      end_in        = end_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = hold_ff;
      rd_addr       = '0;
      case (op)
         OP_CAPTURE: begin
            cmd_in        = req_cmd;
            key_in        = req_key;
            restart_in    = req_restart;
            res_status_in = RS_MISS;
            res_idx_in    = '0;
            lo_in         = '0;
            end_in        = count_ff;
         end
         OP_LOAD: begin
            if (eff_count < DEPTH_C) begin
               wr_en         = 1'b1;
               wr_addr       = eff_count[IW-1:0];
               wr_data       = key_ff;
               count_in      = eff_count + CW'(1);
               res_status_in = RS_LOADED;
            end else begin
               count_in      = eff_count;
               res_status_in = RS_FULL;
            end
         end
         OP_SEQ_FIRST: begin
            rd_addr = last_idx;
            p_in    = last_idx;
         end
         OP_SEQ_SCAN: begin
            if (key_hit) begin
               res_status_in = RS_FOUND;
               res_idx_in    = p_ff;
            end else begin
               p_in    = IW'(p_ff - IW'(1));
               rd_addr = IW'(p_ff - IW'(1));
            end
         end
         OP_SORT_INIT: begin
            lim_in  = last_idx;
            rd_addr = '0;
         end
         OP_SORT_HOLD: begin
            hold_in = rd_data_ff;
            rd_addr = IW'(1);
            j_in    = IW'(1);
         end
         OP_SORT_STEP: begin
            // carry the larger key forward, drop the smaller one behind
            wr_en   = 1'b1;
            wr_addr = IW'(j_ff - IW'(1));
            wr_data = swap ? rd_data_ff : hold_ff;
            if (!swap) begin
               hold_in = rd_data_ff;
            end
            if (j_ff != lim_ff) begin
               rd_addr = IW'(j_ff + IW'(1));
               j_in    = IW'(j_ff + IW'(1));
            end
         end
         OP_SORT_END: begin
            wr_en   = 1'b1;
            wr_addr = lim_ff;
            wr_data = hold_ff;
            lim_in  = IW'(lim_ff - IW'(1));
            rd_addr = '0;
         end
         OP_BS_ADDR: begin
            rd_addr = mid_calc;
            mid_in  = mid_calc;
         end
         OP_BS_CMP: begin
            if (key_hit) begin
               res_status_in = RS_FOUND;
               res_idx_in    = mid_ff;
            end else if (key_gt) begin
               end_in = CW'(mid_ff);
            end else begin
               lo_in = CW'(mid_ff) + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      if (op == OP_POST) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = POS_W'(res_idx_ff);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      restart_ff    <= restart_in;
      p_ff          <= p_in;
      j_ff          <= j_in;
      lim_ff        <= lim_in;
      hold_ff       <= hold_in;
      lo_ff         <= lo_in;
      end_ff        <= end_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.cmd         = cmd_ff;
   assign stat.count_zero  = (count_ff == '0);
   assign stat.count_lt2   = (count_ff < CW'(2));
   assign stat.seq_hit     = key_hit;
   assign stat.seq_at_zero = (p_ff == '0);
   assign stat.j_at_lim    = (j_ff == lim_ff);
   assign stat.lim_at_one  = (lim_ff == IW'(1));
   assign stat.bs_empty    = (lo_ff >= end_ff);
   assign stat.bs_hit      = key_hit;
   assign stat.out_free    = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.position = rsp_pos_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   a_sort_index: assert property (@(posedge clock) disable iff (reset)
      (op == OP_SORT_STEP) |-> ((j_ff <= lim_ff) && (j_ff != '0)))
      else $error("sort index outside current pass");

   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (op == OP_BS_CMP) |-> ((CW'(mid_ff) >= lo_ff) && (CW'(mid_ff) < end_ff)))
      else $error("binary probe outside search range");

   a_post_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_POST) |=> (rsp_valid_ff && (rsp_status_ff == $past(res_status_ff))))
      else $error("result word not posted");

endmodule

FILE: rtl/core/sktab_ctrl.sv
module sktab_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sktab_pkg::dp_stat_type  stat,
   output sktab_pkg::dp_op_type    op
);
   import sktab_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.cmd)
               CMD_LOAD: state_in = ST_RESPOND;
               CMD_SEQ:  state_in = stat.count_zero ? ST_RESPOND : ST_SEQ_SCAN;
               CMD_BIN:  state_in = stat.count_lt2 ? ST_BS_ADDR : ST_SORT_HOLD;
               default:  state_in = ST_RESPOND;
            endcase
         end
         ST_SEQ_SCAN: begin
            if (stat.seq_hit || stat.seq_at_zero) begin
               state_in = ST_RESPOND;
            end
         end
         ST_SORT_HOLD: state_in = ST_SORT_STEP;
         ST_SORT_STEP: begin
            if (stat.j_at_lim) begin
               state_in = ST_SORT_END;
            end
         end
         ST_SORT_END: state_in = stat.lim_at_one ? ST_BS_ADDR : ST_SORT_HOLD;
         ST_BS_ADDR:  state_in = stat.bs_empty ? ST_RESPOND : ST_BS_CMP;
         ST_BS_CMP:   state_in = stat.bs_hit ? ST_RESPOND : ST_BS_ADDR;
         ST_RESPOND: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_CAPTURE;
            end
         end
         ST_DISPATCH: begin
            case (stat.cmd)
               CMD_LOAD: op = OP_LOAD;
               CMD_SEQ:  op = stat.count_zero ? OP_NONE : OP_SEQ_FIRST;
               CMD_BIN:  op = stat.count_lt2 ? OP_NONE : OP_SORT_INIT;
               default:  op = OP_NONE;
            endcase
         end
         ST_SEQ_SCAN:  op = OP_SEQ_SCAN;
         ST_SORT_HOLD: op = OP_SORT_HOLD;
         ST_SORT_STEP: op = OP_SORT_STEP;
         ST_SORT_END:  op = OP_SORT_END;
         ST_BS_ADDR:   op = OP_BS_ADDR;
         ST_BS_CMP:    op = OP_BS_CMP;
         ST_RESPOND:   op = stat.out_free ? OP_POST : OP_NONE;
         default:      op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/static_key_table_search_core.sv
// Channel   Direction  Payload                            Handshake
// req_if    in         cmd[1:0], key[31:0] s, restart     valid / ready
// rsp_if    out        status[1:0], position[5:0]         valid / ready
//
// One word at a time: the next word is accepted only after the result word is posted.
// Load appends the key unless the table is full. Sequential search scans from the last entry
// down. Binary search bubble-sorts n >= 2 entries, then probes until a hit or the range runs
// empty; all paced by the single read and single write port of the key memory.
// Reset clears the entry count and the result valid; keys need no clearing.
// A result word waiting on rsp_if holds the next word in its final state.
module static_key_table_search_core #(
   parameter int TABLE_DEPTH = sktab_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sktab_req_if.sink   req_if,
   sktab_rsp_if.source rsp_if
);
   import sktab_pkg::*;

   // command from sequencer to datapath, status back
   dp_op_type   op;
   dp_stat_type stat;
   logic        req_ready;

   // sequencer: accept a word, walk load / scan / sort / halve, post result
   sktab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   // datapath: key memory, counters, comparators and the result register
   sktab_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_cmd     (req_if.cmd),
      .req_key     (req_if.key),
      .req_restart (req_if.restart),
      .stat        (stat),
      .rsp_if      (rsp_if)
   );

   // ready only while the sequencer sits idle
   assign req_if.ready = req_ready;

endmodule
